[rtl/bytecode_length_framer_core_assert.svh]
// Assertion macros shared by the bytecode length framer modules.
`ifndef BYTECODE_LENGTH_FRAMER_CORE_ASSERT_SVH
`define BYTECODE_LENGTH_FRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BLF_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bytecode framer same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BLF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bytecode framer next-cycle check failed");

`endif

[rtl/blf_pkg.sv]
// Package with the types, codes and sizes of the bytecode length framer.
package blf_pkg;

  // Operand size table geometry.
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned TBL_AW      = $clog2(TABLE_DEPTH);

  typedef logic [TBL_AW-1:0] tbl_addr_t;

  // Input commands.
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_TABLE = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_END           = 3'd1;
  localparam logic [2:0] ST_TRUNC_OP      = 3'd2;
  localparam logic [2:0] ST_BAD_OP        = 3'd3;
  localparam logic [2:0] ST_TRUNC_OPERAND = 3'd4;

  // Configuration register index (byte address bit 2).
  localparam logic [0:0] REG_OPCODE_COUNT = 1'b0;

  // One result word.
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] opcode;
    logic [31:0]        start_offset;
    logic [31:0]        instr_index;
    logic [7:0]         operand_length;
  } result_t;

  // Size table access from the parser.
  typedef struct packed {
    logic      we;
    tbl_addr_t waddr;
    logic [7:0] wdata;
    tbl_addr_t raddr;
  } ram_req_t;

endpackage

[rtl/blf_ram.sv]
// Generic single-write, single-read synchronous RAM with write bypass.
module blf_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; a write to the same entry in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/blf_parse.sv]
// Parser state and per-word framing logic of the bytecode length framer.
module blf_parse
  import blf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [1:0] cmd,
  input  logic [7:0] code_byte,
  input  logic [7:0] table_slot,
  input  logic [7:0] table_operand_bytes,
  input  logic [8:0] opcode_count,
  input  logic [7:0] tbl_rdata,
  output ram_req_t   ram_req,
  output logic       res_valid,
  output result_t    res
);

  `include "bytecode_length_framer_core_assert.svh"

  logic        in_operand_r, in_operand_nxt;
  logic [1:0]  bytes_seen_r, bytes_seen_nxt;
  logic [31:0] word_r, word_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] good_r, good_nxt;
  logic [7:0]  len_r, len_nxt;

  // Next-state and result logic for one accepted word.
  always_comb begin
    logic [31:0] word_new;
    logic [31:0] start_new;
    logic        bad;

    in_operand_nxt = in_operand_r;
    bytes_seen_nxt = bytes_seen_r;
    word_nxt       = word_r;
    left_nxt       = left_r;
    offset_nxt     = offset_r;
    start_nxt      = start_r;
    good_nxt       = good_r;
    len_nxt        = len_r;
    res_valid      = 1'b0;
    res            = '0;
    ram_req.we     = 1'b0;
    ram_req.waddr  = tbl_addr_t'(table_slot);
    ram_req.wdata  = table_operand_bytes;

    // Assemble the opcode word, least significant byte first.
    word_new  = (bytes_seen_r == 2'd0) ? 32'd0 : word_r;
    word_new[8*bytes_seen_r +: 8] = code_byte;
    start_new = (bytes_seen_r == 2'd0) ? offset_r : start_r;
    bad = word_new[31] || (word_new >= {23'd0, opcode_count}) ||
          (word_new >= 32'(TABLE_DEPTH));

    if (accept) begin
      case (cmd)
        CMD_TABLE: begin
          ram_req.we = (32'(table_slot) < 32'(TABLE_DEPTH));
        end
        CMD_END: begin
          res_valid   = 1'b1;
          res.instr_index = good_r;
          if (in_operand_r) begin
            res.status         = ST_TRUNC_OPERAND;
            res.opcode         = word_r;
            res.start_offset   = start_r;
            res.operand_length = len_r;
          end else if (bytes_seen_r != 2'd0) begin
            res.status       = ST_TRUNC_OP;
            res.start_offset = start_r;
          end else begin
            res.status       = ST_END;
            res.start_offset = offset_r;
          end
          in_operand_nxt = 1'b0;
          bytes_seen_nxt = 2'd0;
          word_nxt       = 32'd0;
          left_nxt       = 8'd0;
          offset_nxt     = 32'd0;
          start_nxt      = 32'd0;
          good_nxt       = 32'd0;
          len_nxt        = 8'd0;
        end
        CMD_BYTE: begin
          offset_nxt = offset_r + 32'd1;
          if (in_operand_r) begin
            // Operand byte: the last one closes the instruction.
            left_nxt = left_r - 8'd1;
            if (left_r == 8'd1) begin
              in_operand_nxt     = 1'b0;
              res_valid          = 1'b1;
              res.status         = ST_OK;
              res.opcode         = word_r;
              res.start_offset   = start_r;
              res.instr_index    = good_r;
              res.operand_length = len_r;
              good_nxt           = good_r + 32'd1;
            end
          end else begin
            word_nxt       = word_new;
            start_nxt      = start_new;
            bytes_seen_nxt = bytes_seen_r + 2'd1;
            if (bytes_seen_r == 2'd3) begin
              // Opcode complete: check it and take its operand size.
              res.opcode       = word_new;
              res.start_offset = start_new;
              res.instr_index  = good_r;
              if (bad) begin
                res_valid  = 1'b1;
                res.status = ST_BAD_OP;
              end else begin
                len_nxt = tbl_rdata;
                if (tbl_rdata == 8'd0) begin
                  res_valid  = 1'b1;
                  res.status = ST_OK;
                  good_nxt   = good_r + 32'd1;
                end else begin
                  in_operand_nxt = 1'b1;
                  left_nxt       = tbl_rdata;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    // The table is read ahead at the low bits of the word being built.
    ram_req.raddr = tbl_addr_t'(word_nxt);
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_operand_r <= 1'b0;
      bytes_seen_r <= 2'd0;
      word_r       <= 32'd0;
      left_r       <= 8'd0;
      offset_r     <= 32'd0;
      start_r      <= 32'd0;
      good_r       <= 32'd0;
      len_r        <= 8'd0;
    end else begin
      in_operand_r <= in_operand_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      word_r       <= word_nxt;
      left_r       <= left_nxt;
      offset_r     <= offset_nxt;
      start_r      <= start_nxt;
      good_r       <= good_nxt;
      len_r        <= len_nxt;
    end
  end

  // While operand bytes are counted, no opcode bytes are held and the count is live.
  `BLF_ASSERT(a_operand_no_opbytes, in_operand_r, bytes_seen_r == 2'd0)
  `BLF_ASSERT(a_operand_left_nz, in_operand_r, left_r != 8'd0)
  `BLF_ASSERT_NEXT(a_ok_bumps_count, res_valid && (res.status == ST_OK),
                   good_r == $past(good_r) + 32'd1)

endmodule

[rtl/blf_skid.sv]
// Output register with one skid entry for the result channel.
module blf_skid
  import blf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_data,
  output logic    full
);

  `include "bytecode_length_framer_core_assert.svh"

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;

  // Fill the output register first; park in the skid entry while it is held.
  always_comb begin
    logic drain;
    drain          = out_valid_r && !out_stall;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (drain || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign full      = skid_valid_r;

  // The skid entry is only used behind a held output word, and blocks new results.
  `BLF_ASSERT(a_skid_behind_out, skid_valid_r, out_valid_r)
  `BLF_ASSERT(a_no_push_when_full, skid_valid_r, !push)
  // A stalled output word stays valid and unchanged.
  `BLF_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall,
                   out_valid_r && (out_data_r == $past(out_data_r)))

endmodule

[rtl/bytecode_length_framer_core.sv]
// Bytecode length framer: splits a byte stream into instructions and reports each one.
//
// Input channel (in_valid / in_stall): one command word per cycle unless stalled.
// A code byte command feeds the parser, an end command reports how the stream
// ended and clears the offsets and counters, and a table command loads the
// operand byte count of one opcode into the size table.
// Output channel (out_valid / out_stall): one word per instruction, bad opcode
// or end command, with status, opcode, start offset, index and operand length.
// Throughput is one input word per cycle while in_stall is low. A result is
// registered into the output register, or into the skid entry while that is
// held. The size table RAM is read ahead at the low bits of the opcode being
// assembled, so the lookup is ready when the last opcode byte arrives.
// When out_stall holds a result, one more result parks in a skid entry; in_stall
// is raised while that entry is occupied.
// Reset (synchronous, rst_n low) clears the parser, the counters, the output
// channel and opcode_count. The size table is not cleared: an entry must be
// written before an opcode that uses it is parsed. opcode_count is written via APB at
// byte address 0; the user must do so only while idle, the block does not enforce it.
module bytecode_length_framer_core
  import blf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_code_byte,
  input  logic [7:0]         in_table_slot,
  input  logic [7:0]         in_table_operand_bytes,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_opcode,
  output logic [31:0]        out_start_offset,
  output logic [31:0]        out_instr_index,
  output logic [7:0]         out_operand_length,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [8:0] opcode_count_r;
  logic       accept;
  logic       res_valid;
  result_t    res;
  result_t    out_data;
  ram_req_t   ram_req;
  logic [7:0] tbl_rdata;
  logic       skid_full;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opcode_count_r <= 9'd0;
    end else if (psel && penable && pwrite && (paddr[2:2] == REG_OPCODE_COUNT)) begin
      opcode_count_r <= pwdata[8:0];
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      REG_OPCODE_COUNT: prdata = {23'd0, opcode_count_r};
      default:          prdata = 32'd0;
    endcase
  end

  // Input handshake.
  assign in_stall = skid_full;
  assign accept   = in_valid && !in_stall;

  blf_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (8)
  ) u_size_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (tbl_rdata)
  );

  blf_parse u_parse (
    .clk                 (clk),
    .rst_n               (rst_n),
    .accept              (accept),
    .cmd                 (in_cmd),
    .code_byte           (in_code_byte),
    .table_slot          (in_table_slot),
    .table_operand_bytes (in_table_operand_bytes),
    .opcode_count        (opcode_count_r),
    .tbl_rdata           (tbl_rdata),
    .ram_req             (ram_req),
    .res_valid           (res_valid),
    .res                 (res)
  );

  blf_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (skid_full)
  );

  // Result fields.
  assign out_status         = out_data.status;
  assign out_opcode         = out_data.opcode;
  assign out_start_offset   = out_data.start_offset;
  assign out_instr_index    = out_data.instr_index;
  assign out_operand_length = out_data.operand_length;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the bytecode length framer core.
`timescale 1ns / 1ps

module testbench;
  import blf_pkg::*;

  // The one command code the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_cmd = CMD_BYTE;
  logic [7:0]         in_code_byte = 8'd0;
  logic [7:0]         in_table_slot = 8'd0;
  logic [7:0]         in_table_operand_bytes = 8'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_status;
  logic signed [31:0] out_opcode;
  logic [31:0]        out_start_offset;
  logic [31:0]        out_instr_index;
  logic [7:0]         out_operand_length;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = 3'd0;
  logic [31:0]        pwdata = 32'd0;
  logic [31:0]        prdata;
  logic               pready;

  // Parser copy kept in step with every accepted word.
  logic        mid_operand = 1'b0;
  int          held_bytes = 0;
  logic [31:0] word_acc = '0;
  logic [7:0]  operand_left = '0;
  logic [31:0] byte_pos = '0;
  logic [31:0] instr_begin = '0;
  logic [31:0] good_instrs = '0;
  logic [7:0]  cur_len = '0;
  logic [7:0]  size_tab [0:TABLE_DEPTH-1];
  logic [8:0]  op_count = '0;

  result_t pending_results [$];
  int      errors = 0;
  int      words_sent = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_request = 0;

  bytecode_length_framer_core DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_cmd                 (in_cmd),
    .in_code_byte           (in_code_byte),
    .in_table_slot          (in_table_slot),
    .in_table_operand_bytes (in_table_operand_bytes),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_opcode             (out_opcode),
    .out_start_offset       (out_start_offset),
    .out_instr_index        (out_instr_index),
    .out_operand_length     (out_operand_length),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Queue one expected result word, tagged with the current good count.
  function automatic void push_result(logic [2:0] status, logic [31:0] op,
                                      logic [31:0] start, logic [7:0] len);
    result_t r;
    r.status         = status;
    r.opcode         = op;
    r.start_offset   = start;
    r.instr_index    = good_instrs;
    r.operand_length = len;
    pending_results.push_back(r);
  endfunction

  // Advance the parser copy by one accepted input word.
  function automatic void frame_word(logic [1:0] cmd, logic [7:0] b,
                                     logic [7:0] slot, logic [7:0] size);
    case (cmd)
      CMD_TABLE: begin
        size_tab[slot] = size;
      end
      CMD_END: begin
        if (mid_operand) begin
          push_result(ST_TRUNC_OPERAND, word_acc, instr_begin, cur_len);
        end else if (held_bytes != 0) begin
          push_result(ST_TRUNC_OP, '0, instr_begin, '0);
        end else begin
          push_result(ST_END, '0, byte_pos, '0);
        end
        mid_operand  = 1'b0;
        held_bytes   = 0;
        word_acc     = '0;
        operand_left = '0;
        byte_pos     = '0;
        instr_begin  = '0;
        good_instrs  = '0;
        cur_len      = '0;
      end
      CMD_BYTE: begin
        byte_pos = byte_pos + 32'd1;
        if (mid_operand) begin
          operand_left = operand_left - 8'd1;
          if (operand_left == 8'd0) begin
            mid_operand = 1'b0;
            push_result(ST_OK, word_acc, instr_begin, cur_len);
            good_instrs = good_instrs + 32'd1;
          end
          return;
        end
        // Opcode bytes arrive least significant first.
        if (held_bytes == 0) begin
          instr_begin = byte_pos - 32'd1;
          word_acc    = '0;
        end
        word_acc[8*held_bytes +: 8] = b;
        held_bytes = held_bytes + 1;
        if (held_bytes < 4) return;
        held_bytes = 0;
        if (word_acc[31] || word_acc >= op_count || word_acc >= TABLE_DEPTH) begin
          push_result(ST_BAD_OP, word_acc, instr_begin, '0);
          return;
        end
        cur_len = size_tab[tbl_addr_t'(word_acc)];
        if (cur_len == 8'd0) begin
          push_result(ST_OK, word_acc, instr_begin, '0);
          good_instrs = good_instrs + 32'd1;
        end else begin
          mid_operand  = 1'b1;
          operand_left = cur_len;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  // Compare every result word taken with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected, status %0d", out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("opcode", want.opcode, out_opcode);
        check_field("start_offset", want.start_offset, out_start_offset);
        check_field("instr_index", want.instr_index, out_instr_index);
        check_field("operand_length", 32'(want.operand_length),
                    32'(out_operand_length));
      end
    end
  end

  // Result side stall: a requested hold-off first, random stalls otherwise.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_request = hold_request - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one word, with random gaps ahead of it, and wait until it is taken.
  task automatic send_word(logic [1:0] cmd, logic [7:0] b, logic [7:0] slot,
                           logic [7:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_cmd                 <= cmd;
    in_code_byte           <= b;
    in_table_slot          <= slot;
    in_table_operand_bytes <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_word(cmd, b, slot, size);
    if (cmd != CMD_UNUSED) words_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(CMD_BYTE, b, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_end();
    send_word(CMD_END, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_table(logic [7:0] slot, logic [7:0] size);
    send_word(CMD_TABLE, 8'($urandom), slot, size);
  endtask

  // Stop sending and wait until every expected result has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // Table writes give no result and may still be in flight.
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_opcode_count(logic [8:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_OPCODE_COUNT, 2'b00};
    pwdata  <= {23'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    op_count = value;
  endtask

  // Operand sizes: mostly short, now and then the largest.
  function automatic logic [7:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 95) return 8'($urandom_range(4));
    if (r < 97) return 8'd255;
    return 8'($urandom_range(5, 254));
  endfunction

  // Opcode words: mostly valid, the rest negative, out of range or random.
  function automatic logic [31:0] pick_opcode();
    int r;
    r = $urandom_range(99);
    if (op_count != 0 && r < 75) return $urandom_range(op_count - 1);
    if (r < 85) return {1'b1, 31'($urandom)};
    if (r < 93) return $urandom_range(op_count, 511);
    return $urandom;
  endfunction

  // One instruction with random content, sometimes cut short or broken up.
  task automatic send_instruction();
    logic [31:0] word;
    int          r;
    int          cut;
    int          len;
    r = $urandom_range(99);
    if (r < 3) begin
      case ($urandom_range(2))
        0: send_byte(8'($urandom));
        1: send_word(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
        default: send_table(8'($urandom), pick_size());
      endcase
      return;
    end
    if (r < 8) begin
      send_end();
      return;
    end
    word = pick_opcode();
    cut  = ($urandom_range(99) < 5) ? int'($urandom_range(1, 3)) : 4;
    len  = 0;
    if (!word[31] && word < op_count && word < TABLE_DEPTH) begin
      len = int'(size_tab[tbl_addr_t'(word)]);
    end
    for (int i = 0; i < cut; i++) send_byte(word[8*i +: 8]);
    if (cut < 4) begin
      send_end();
      return;
    end
    for (int i = 0; i < len; i++) begin
      // A table rewrite here must not change the latched operand length.
      if ($urandom_range(99) < 3) send_table(word[7:0], pick_size());
      if ($urandom_range(99) < 2) begin
        send_end();
        return;
      end
      send_byte(8'($urandom));
    end
  endtask

  // End marker on an empty stream.
  task automatic test_empty_stream();
    send_end();
  endtask

  // With no valid opcodes, even opcode zero is bad; the end reports the offset.
  task automatic test_zero_count();
    repeat (4) send_byte(8'h00);
    send_end();
  endtask

  // Extreme opcodes, zero operand bytes, mid-instruction table rewrite,
  // the ignored command and a truncated opcode.
  task automatic test_special_opcodes();
    write_opcode_count(9'd256);
    send_table(8'd0, 8'd0);
    send_table(8'd255, 8'd3);
    send_table(8'd7, 8'd255);
    repeat (4) send_byte(8'h00);
    send_byte(8'hff);
    repeat (3) send_byte(8'h00);
    send_byte(8'($urandom));
    send_table(8'd255, 8'd0);
    repeat (2) send_byte(8'($urandom));
    repeat (4) send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);
    send_word(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
    send_byte(8'h00);
    send_byte(8'h01);
    send_end();
  endtask

  // Fill every table entry so that no lookup ever hits an unwritten one.
  task automatic test_table_load();
    for (int s = 0; s < TABLE_DEPTH; s++) send_table(8'(s), pick_size());
  endtask

  task automatic test_random_stream(logic [8:0] count, int send_pct, int recv_pct, int n);
    int stop;
    write_opcode_count(count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop = words_sent + n;
    while (words_sent < stop) send_instruction();
  endtask

  // Long receiver hold-off while bad opcodes keep coming, so the block fills up.
  task automatic test_output_backpressure();
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 60;
    repeat (12) begin
      repeat (4) send_byte(8'hff);
    end
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 19;
    recv_idle_pct = 68;
    test_empty_stream();
    test_zero_count();
    test_special_opcodes();
    test_table_load();
    test_random_stream(9'd256, 19, 68, 480);
    test_random_stream(9'($urandom_range(2, 255)), 68, 19, 480);
    test_random_stream(9'd1, 0, 0, 250);
    test_output_backpressure();
    test_random_stream(9'd0, 0, 0, 80);
    test_random_stream(9'($urandom_range(1, 256)), 0, 0, 100);
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
